// File: rtl/core/frt_pkg.sv
// Shared types and constants of the firewall rule table.
// Used by the rule cells, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
package frt_pkg;

  typedef struct packed {
    logic signed [31:0] id;
    logic [7:0]         direction;
    logic [31:0]        source_addr;
    logic [31:0]        dest_addr;
    logic [15:0]        source_port;
    logic [15:0]        dst_port;
    logic [7:0]         protocol;
    logic [7:0]         verdict;
  } rule_t;

  typedef logic [1:0] cell_mode_t;

  localparam cell_mode_t MODE_HOLD  = 2'd0;
  localparam cell_mode_t MODE_SHIFT = 2'd1;
  localparam cell_mode_t MODE_LOAD  = 2'd2;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;

endpackage

// File: rtl/core/firewall_rule_table_top.sv
// Top level of the firewall rule table: a chain of rule cells and the command
// sequencer with its output register. Depends on frt_pkg and frt_cell.
//
//   channel  signals                  direction
//   in       in_valid / in_ready      command word into the table
//   out      out_valid / out_ready    result word out of the table
//
// Each command rotates the whole chain once, step by step, with the
// head cell examined at each step; add, delete and update then end with
// an acknowledge step, and list starts with a count step up front.
// A list with no dynamic rules ends after the count word. A stalled output
// word halts the rotation. Reset empties the table at once.
`timescale 1ns / 1ps
module firewall_rule_table_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] rule_id,
  input  logic [7:0]         direction,
  input  logic [31:0]        source_addr,
  input  logic [31:0]        dest_addr,
  input  logic [15:0]        source_port,
  input  logic [15:0]        dst_port,
  input  logic [7:0]         protocol,
  input  logic [7:0]         verdict,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic               ok,
  output logic [5:0]         dyn_count,
  output logic signed [31:0] out_id,
  output logic [7:0]         out_direction,
  output logic [31:0]        out_source_addr,
  output logic [31:0]        out_dest_addr,
  output logic [15:0]        out_source_port,
  output logic [15:0]        out_dst_port,
  output logic [7:0]         out_protocol,
  output logic [7:0]         out_verdict,
  output logic               last
);
  import frt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_STEP = CW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [1:0]    cmd_op;
  rule_t         cmd;
  logic [CW-1:0] count;
  logic [CW-1:0] dyn;
  logic [CW-1:0] step;
  logic [CW-1:0] hit;
  logic [CW-1:0] emitted;
  logic          found;
  logic          dup;

  logic          ov;
  logic [1:0]    o_kind;
  logic          o_ok;
  logic [CW-1:0] o_dyn;
  rule_t         o_rule;
  logic          o_last;

  rule_t      cells [TABLE_DEPTH];
  cell_mode_t modes [TABLE_DEPTH];
  rule_t      feed;
  rule_t      head;

  logic can, valid_here, first_hit, same, add_ok, load_out;

  assign head = cells[0];
  assign can = !ov || out_ready;
  assign valid_here = step < count;
  assign first_hit = valid_here && head.id == cmd.id && !found;
  assign same = head.direction == cmd.direction && head.source_addr == cmd.source_addr
      && head.dest_addr == cmd.dest_addr && head.source_port == cmd.source_port
      && head.dst_port == cmd.dst_port && head.protocol == cmd.protocol
      && head.verdict == cmd.verdict;
  assign add_ok = !dup && count < DEPTH;
  assign load_out = can && (state == S_HEAD || state == S_DONE
      || (state == S_WALK && cmd_op == OP_LIST && valid_here && head.id[31]));

  always_comb begin
    feed = head;
    if (cmd_op == OP_UPDATE && first_hit) begin
      feed = cmd;
      feed.id = head.id;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      modes[i] = MODE_HOLD;
      if (state == S_WALK && can) begin
        modes[i] = MODE_SHIFT;
      end else if (state == S_DONE && can) begin
        if (cmd_op == OP_ADD && add_ok && count == CW'(i)) begin
          modes[i] = MODE_LOAD;
        end else if (cmd_op == OP_DELETE && found && CW'(i) >= hit
            && i < TABLE_DEPTH - 1) begin
          modes[i] = MODE_SHIFT;
        end
      end
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_tail
      frt_cell u_cell (
        .clk(clk), .mode(modes[g]), .neighbor(feed), .load_rule(cmd), .rule(cells[g])
      );
    end else begin : g_body
      frt_cell u_cell (
        .clk(clk), .mode(modes[g]), .neighbor(cells[g+1]), .load_rule(cmd),
        .rule(cells[g])
      );
    end
  end

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
      count <= '0;
      dyn <= '0;
    end else begin
      if (load_out) begin
        ov <= 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_op <= opcode;
            cmd <= '{rule_id, direction, source_addr, dest_addr, source_port,
                     dst_port, protocol, verdict};
            step <= '0;
            found <= 1'b0;
            dup <= 1'b0;
            emitted <= '0;
            state <= (opcode == OP_LIST) ? S_HEAD : S_WALK;
          end
        end
        S_HEAD: begin
          if (can) begin
            o_kind <= KIND_COUNT;
            o_ok <= 1'b0;
            o_dyn <= dyn;
            o_rule <= '0;
            o_last <= dyn == '0;
            state <= (dyn == '0) ? S_IDLE : S_WALK;
          end
        end
        S_WALK: begin
          if (can) begin
            step <= step + 1'b1;
            if (first_hit) begin
              found <= 1'b1;
              hit <= step;
            end
            if (cmd_op == OP_ADD && valid_here && same) begin
              dup <= 1'b1;
            end
            if (cmd_op == OP_LIST && valid_here && head.id[31]) begin
              o_kind <= KIND_ENTRY;
              o_ok <= 1'b0;
              o_dyn <= '0;
              o_rule <= head;
              o_last <= emitted + 1'b1 == dyn;
              emitted <= emitted + 1'b1;
            end
            if (step == LAST_STEP) begin
              state <= (cmd_op == OP_LIST) ? S_IDLE : S_DONE;
            end
          end
        end
        default: begin
          if (can) begin
            o_kind <= KIND_ACK;
            o_ok <= (cmd_op == OP_ADD) ? add_ok : 1'b1;
            o_dyn <= '0;
            o_rule <= '0;
            o_last <= 1'b1;
            if (cmd_op == OP_ADD && add_ok) begin
              count <= count + 1'b1;
              if (cmd.id[31]) begin
                dyn <= dyn + 1'b1;
              end
            end else if (cmd_op == OP_DELETE && found) begin
              count <= count - 1'b1;
              if (cmd.id[31]) begin
                dyn <= dyn - 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid = ov;
  assign kind = o_kind;
  assign ok = o_ok;
  assign dyn_count = 6'(o_dyn);
  assign out_id = o_rule.id;
  assign out_direction = o_rule.direction;
  assign out_source_addr = o_rule.source_addr;
  assign out_dest_addr = o_rule.dest_addr;
  assign out_source_port = o_rule.source_port;
  assign out_dst_port = o_rule.dst_port;
  assign out_protocol = o_rule.protocol;
  assign out_verdict = o_rule.verdict;
  assign last = o_last;

endmodule

// File: rtl/core/frt_cell.sv
// One rule cell of the table chain: holds a rule, takes its neighbor's rule
// or a new rule. Depends on frt_pkg.
`timescale 1ns / 1ps
module frt_cell (
  input  logic               clk,
  input  frt_pkg::cell_mode_t mode,
  input  frt_pkg::rule_t     neighbor,
  input  frt_pkg::rule_t     load_rule,
  output frt_pkg::rule_t     rule
);
  import frt_pkg::*;

  always_ff @(posedge clk) begin
    case (mode)
      MODE_SHIFT: rule <= neighbor;
      MODE_LOAD:  rule <= load_rule;
      default:    rule <= rule;
    endcase
  end

endmodule

// File: rtl/core/frt_checker.sv
// Port-level checks of the firewall rule table and the bind that attaches
// them to the top level. Depends on frt_pkg and firewall_rule_table_top.
`timescale 1ns / 1ps
module frt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic       ok,
  input logic       last
);
  import frt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
    else $error("Stalled output word changed.");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ACK |-> last)
    else $error("Acknowledge word without last.");

  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ENTRY |-> !ok)
    else $error("Rule entry word with ok set.");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second command taken while one is in progress.");

endmodule

bind firewall_rule_table_top frt_checker u_frt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .ok(ok), .last(last)
);
